FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/tsd_pkg.sv
// types, constants and the crc helper of the thermometer scratchpad decoder
package tsd_pkg;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ROM_CRC = 2'd1,
		ST_FAMILY  = 2'd2,
		ST_PAD_CRC = 2'd3
	} status_t;

	// frame phase, one-hot
	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_ROM  = 3'b010,
		PH_PAD  = 3'b100
	} phase_t;

	// resolution field codes (scratchpad byte 4, bits 6:5)
	localparam logic [1:0] RES_9BIT  = 2'd0;
	localparam logic [1:0] RES_10BIT = 2'd1;
	localparam logic [1:0] RES_11BIT = 2'd2;
	localparam logic [1:0] RES_12BIT = 2'd3;

	// family codes
	localparam logic [7:0] FAM_NINE_BIT = 8'h10;
	localparam logic [7:0] FAM_TWELVE_A = 8'h28;
	localparam logic [7:0] FAM_TWELVE_B = 8'h22;

	// byte positions
	localparam logic [3:0] ROM_CRC_IDX  = 4'd7;
	localparam logic [3:0] PAD_CRC_IDX  = 4'd8;
	localparam logic [3:0] PAD_TEMP_LO  = 4'd0;
	localparam logic [3:0] PAD_TEMP_HI  = 4'd1;
	localparam logic [3:0] PAD_CONFIG   = 4'd4;
	localparam logic [3:0] PAD_REMAIN   = 4'd6;
	localparam logic [3:0] PAD_PER_DEG  = 4'd7;

	localparam logic [7:0]  CRC_POLY       = 8'h8C;
	localparam logic [7:0]  COUNT_PER_DEG  = 8'h10;
	localparam logic [15:0] MASK_WHOLE     = 16'hFFF0;
	localparam logic [15:0] MASK_RES_9BIT  = 16'hFFF8;
	localparam logic [15:0] MASK_RES_10BIT = 16'hFFFC;
	localparam logic [15:0] MASK_RES_11BIT = 16'hFFFE;
	localparam logic [15:0] REMAIN_BIAS    = 16'd12;

	// one finished frame, handed from front to back
	typedef struct packed {
		status_t    status;
		logic [7:0] family;
		logic       ext;
		logic [7:0] temp_lo;
		logic [7:0] temp_hi;
		logic [1:0] res;
		logic [7:0] remain;
		logic       per_deg_ok;
	} job_t;

	// reflected crc-8 over one byte, lsb first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		logic [7:0] d;
		c = crc_in;
		d = data;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ d[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
			d = d >> 1;
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/tsd_intf.sv
// channel interfaces: received bytes in, decoded results out
interface tsd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface tsd_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [15:0] temperature;
	logic [7:0]         sensor_family;
	logic               extended_family;

	modport source (output valid, output status, output temperature, output sensor_family,
		output extended_family, input ready);
	modport sink (input valid, input status, input temperature, input sensor_family,
		input extended_family, output ready);
endinterface

FILE: hw/rtl/tsd_front.sv
// front end: byte sequencing, crc check, field capture, job push
`include "assert_macros.svh"

module tsd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	input  logic          frame_start,
	output logic          push,
	output tsd_pkg::job_t push_job
);
	import tsd_pkg::*;

	phase_t     phase_q;
	logic [3:0] cnt_q;
	logic [7:0] crc_q;
	logic [7:0] family_q;
	logic       ext_q;
	logic [7:0] temp_lo_q;
	logic [7:0] temp_hi_q;
	logic [1:0] res_q;
	logic [7:0] remain_q;
	logic       per_deg_q;

	phase_t     cur_phase;
	logic [3:0] cur_cnt;
	logic [7:0] cur_crc;
	logic [7:0] crc_upd;
	logic       known_family;

	phase_t     phase_d;
	logic [3:0] cnt_d;
	logic [7:0] crc_d;
	logic       emit;
	status_t    emit_status;

	// frame start restarts the sequence on this byte
	assign cur_phase = frame_start ? PH_ROM : phase_q;
	assign cur_cnt   = frame_start ? 4'd0 : cnt_q;
	assign cur_crc   = frame_start ? 8'd0 : crc_q;
	assign crc_upd   = crc8_byte(cur_crc, data_byte);

	assign known_family = (family_q == FAM_NINE_BIT) || (family_q == FAM_TWELVE_A)
		|| (family_q == FAM_TWELVE_B);

	always_comb begin
		phase_d     = cur_phase;
		cnt_d       = cur_cnt;
		crc_d       = cur_crc;
		emit        = 1'b0;
		emit_status = ST_OK;
		unique case (cur_phase)
			PH_ROM: begin
				if (cur_cnt < ROM_CRC_IDX) begin
					crc_d = crc_upd;
					cnt_d = cur_cnt + 4'd1;
				end else if (cur_crc != data_byte) begin
					emit        = 1'b1;
					emit_status = ST_ROM_CRC;
				end else if (!known_family) begin
					emit        = 1'b1;
					emit_status = ST_FAMILY;
				end else begin
					phase_d = PH_PAD;
					cnt_d   = 4'd0;
					crc_d   = 8'd0;
				end
			end
			PH_PAD: begin
				if (cur_cnt < PAD_CRC_IDX) begin
					crc_d = crc_upd;
					cnt_d = cur_cnt + 4'd1;
				end else begin
					emit        = 1'b1;
					emit_status = (cur_crc != data_byte) ? ST_PAD_CRC : ST_OK;
				end
			end
			default: begin
			end
		endcase
		if (emit) begin
			phase_d = PH_IDLE;
			cnt_d   = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cnt_q     <= 4'd0;
			crc_q     <= 8'd0;
			family_q  <= 8'd0;
			ext_q     <= 1'b0;
			temp_lo_q <= 8'd0;
			temp_hi_q <= 8'd0;
			res_q     <= 2'd0;
			remain_q  <= 8'd0;
			per_deg_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			crc_q   <= crc_d;
			if (cur_phase == PH_ROM && cur_cnt == 4'd0) begin
				family_q <= data_byte;
				ext_q    <= (data_byte == FAM_NINE_BIT);
			end
			if (cur_phase == PH_PAD) begin
				unique case (cur_cnt)
					PAD_TEMP_LO: temp_lo_q <= data_byte;
					PAD_TEMP_HI: temp_hi_q <= data_byte;
					PAD_CONFIG:  res_q     <= data_byte[6:5];
					PAD_REMAIN:  remain_q  <= data_byte;
					PAD_PER_DEG: per_deg_q <= (data_byte == COUNT_PER_DEG);
					default: begin
					end
				endcase
			end
		end
	end

	assign push = accept && emit;

	always_comb begin
		push_job            = '0;
		push_job.status     = emit_status;
		push_job.family     = family_q;
		push_job.ext        = ext_q;
		push_job.temp_lo    = temp_lo_q;
		push_job.temp_hi    = temp_hi_q;
		push_job.res        = res_q;
		push_job.remain     = remain_q;
		push_job.per_deg_ok = per_deg_q;
	end

	`ASSERT_IMPLIES(a_idle_count_zero, clk, arst_n, phase_q == PH_IDLE, cnt_q == 4'd0)
	`ASSERT_IMPLIES(a_rom_count_range, clk, arst_n, phase_q == PH_ROM, cnt_q <= ROM_CRC_IDX)

endmodule

FILE: hw/rtl/tsd_queue.sv
// short job queue between front and back
`include "assert_macros.svh"

module tsd_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tsd_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output tsd_pkg::job_t pop_job,
	output logic          empty
);
	import tsd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`ASSERT_IMPLIES(a_no_overflow, clk, arst_n, push, !full)
	`ASSERT_IMPLIES(a_no_underflow, clk, arst_n, pop, !empty)

endmodule

FILE: hw/rtl/tsd_back.sv
// back end: temperature decode and output register
`include "assert_macros.svh"

module tsd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	input  tsd_pkg::job_t    job,
	output logic             pop,
	tsd_res_if.source        result
);
	import tsd_pkg::*;

	logic [15:0] raw;
	logic [15:0] shifted;
	logic [15:0] decoded;
	logic [15:0] temp_out;
	logic        load;

	logic        valid_q;
	status_t     status_q;
	logic [15:0] temp_q;
	logic [7:0]  family_q;
	logic        ext_q;

	assign raw     = {job.temp_hi, job.temp_lo};
	assign shifted = {raw[12:0], 3'b000};

	always_comb begin
		if (job.ext) begin
			if (job.per_deg_ok) begin
				decoded = (shifted & MASK_WHOLE) + REMAIN_BIAS - {8'd0, job.remain};
			end else begin
				decoded = shifted;
			end
		end else begin
			case (job.res)
				RES_9BIT:  decoded = raw & MASK_RES_9BIT;
				RES_10BIT: decoded = raw & MASK_RES_10BIT;
				RES_11BIT: decoded = raw & MASK_RES_11BIT;
				RES_12BIT: decoded = raw;
				default:   decoded = raw;
			endcase
		end
	end

	assign temp_out = (job.status == ST_OK) ? decoded : 16'd0;

	// output stage refills when empty or being drained
	assign load = !valid_q || result.ready;
	assign pop  = job_valid && load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= job.status;
			temp_q   <= temp_out;
			family_q <= job.family;
			ext_q    <= job.ext;
		end
	end

	assign result.valid           = valid_q;
	assign result.status          = status_q;
	assign result.temperature     = temp_q;
	assign result.sensor_family   = family_q;
	assign result.extended_family = ext_q;

	`ASSERT_IMPLIES(a_error_temp_zero, clk, arst_n,
		result.valid && (result.status != ST_OK), result.temperature == 16'sd0)

endmodule

FILE: hw/rtl/thermometer_scratchpad_decoder.sv
// top level of the thermometer scratchpad decoder
//
//  channel  | dir | payload                                       | handshake
//  ---------+-----+-----------------------------------------------+-------------
//  rx       | in  | data_byte[7:0], frame_start                   | valid/ready
//  result   | out | status[1:0], temperature[15:0] signed,        | valid/ready
//           |     | sensor_family[7:0], extended_family           |
//
// one byte is taken per cycle while the job queue has room; the crc update and field
// capture in the front end set that figure. after the closing byte, a result passes
// through the job queue and then the decode and output register.
// reset clears the sequencer, queue pointers and the output valid at once.
// rx.ready drops only while the job queue is full, which happens only when the
// result side stalls long enough for QUEUE_DEPTH + 1 finished frames to back up: one in the
// output register and QUEUE_DEPTH (two by default) in the queue.
`include "assert_macros.svh"

module thermometer_scratchpad_decoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	tsd_rx_if.sink     rx,
	tsd_res_if.source  result
);
	import tsd_pkg::*;

	logic accept;
	logic push;
	job_t push_job;
	logic full;
	logic pop;
	job_t pop_job;
	logic empty;

	// a byte transfer needs only room in the queue for a possible result
	assign rx.ready = !full;
	assign accept   = rx.valid && rx.ready;

	// front: sequencing over rom and scratchpad bytes, crc, classification
	tsd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (rx.data_byte),
		.frame_start (rx.frame_start),
		.push        (push),
		.push_job    (push_job)
	);

	// queue: lets the front keep taking bytes while the result side stalls
	tsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	// back: temperature decode and result register
	tsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!empty),
		.job       (pop_job),
		.pop       (pop),
		.result    (result)
	);

	// a result transfer on the same edge as a full stall must free a slot next cycle
	`ASSERT_NEXT(a_drain_frees_slot, clk, arst_n, full && pop && !push, !full)

endmodule
